// ===== rtl/dftr_pkg.sv =====
// Shared types, widths and constant functions of the direct real-input DFT.
// Used by the front, queue and back modules and by the top level; no dependencies.
`timescale 1ns / 1ps

package dftr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IDX_MAX_W   = 6;
  localparam int BIN_W       = 6;
  localparam int PART_W      = 23;
  localparam int FREQ_W      = 38;
  localparam int STEP_W      = 32;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 38;
  localparam int FRAC_DROP   = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [STEP_W-1:0] FREQ_STEP_RESET = 32'd65536;

  // pi in Q4.28
  localparam longint unsigned PI_Q28 = 64'd843314857;
  localparam int TAYLOR_TERMS = 12;

  // Taylor divisors: (2i-1)(2i) for cosine, (2i)(2i+1) for sine
  localparam longint unsigned COS_DIV [TAYLOR_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};
  localparam longint unsigned SIN_DIV [TAYLOR_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  // one sample as it travels from the front to the back
  typedef struct packed {
    logic [IDX_MAX_W-1:0]        idx;
    logic                        last;
    logic signed [SAMPLE_W-1:0]  sample;
  } q_entry_t;

  typedef enum logic {
    B_LOAD,
    B_RUN
  } back_state_t;

  // Q28 Taylor series of cos (odd = 0) or sin (odd = 1)
  function automatic logic signed [63:0] taylor_q28(input logic [63:0] theta,
                                                    input logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (theta * theta) >> 28;
    term = odd ? theta : (64'd1 << 28);
    sum  = signed'(term);
    for (int i = 0; i < TAYLOR_TERMS; i++) begin
      if (odd) begin
        term = ((term * x2) >> 28) / SIN_DIV[i];
      end else begin
        term = ((term * x2) >> 28) / COS_DIV[i];
      end
      // first correction term subtracts, then the signs alternate
      if (i[0] == 1'b0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  // round magnitude to Q1.15, saturate
  function automatic logic signed [COEF_W-1:0] q28_to_q15(input logic signed [63:0] v);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] r;
    logic signed [COEF_W-1:0] res;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    r   = (mag + 64'd4096) >> 13;
    if (neg) begin
      res = (r >= 64'd32768) ? 16'sh8000 : -signed'(16'(r));
    end else begin
      res = (r > 64'd32767) ? 16'sh7fff : signed'(16'(r));
    end
    return res;
  endfunction

  function automatic logic signed [COEF_W-1:0] cos_q15(input logic [63:0] theta);
    return q28_to_q15(taylor_q28(theta, 1'b0));
  endfunction

  function automatic logic signed [COEF_W-1:0] sin_q15(input logic [63:0] theta,
                                                       input logic neg);
    logic signed [63:0] s;
    s = taylor_q28(theta, 1'b1);
    if (neg) begin
      s = -s;
    end
    return q28_to_q15(s);
  endfunction

endpackage

// ===== rtl/direct_dft_real_input.sv =====
// Top level of the direct real-input DFT: front end, sample queue, compute engine.
// Depends on dftr_pkg, dftr_front, dftr_queue, dftr_back (and dftr_ram below it).
`timescale 1ns / 1ps

// Usage
//   Input: drive in_sample and raise start; the word is taken at a rising edge
//   with start high and busy low. Every POINTS words form one block, in order
//   of time; the word that completes a block launches the transform.
//   Config: cfg_freq_step (unsigned Q16.16) is written on cfg_valid && cfg_ready;
//   cfg_ready is always high. Write it only while the block is idle.
//   Output: one word per bin, bins 0..POINTS-1 in order, each on the out_ ports
//   for exactly one cycle with out_valid high; out_last_bin marks the final bin.
//   The receiver cannot stall, so nothing is held back on the output side.
// Timing
//   A word is accepted while busy is low; a short queue takes up to four words
//   while the engine is busy, then busy rises until the engine takes one out.
//   One multiply-accumulate per cycle on a shared multiplier pair and one RAM
//   read port; the engine takes no words from the queue while it runs a block.
// Reset
//   rst_n (synchronous, active low) empties the queue, restarts the block count,
//   stops any transform and sets freq_step to 1.0 (65536); the store keeps its words.

module direct_dft_real_input #(
  parameter int POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_freq_step,
  output logic               out_valid,
  output logic [5:0]         out_bin_index,
  output logic signed [22:0] out_real_part,
  output logic signed [22:0] out_imag_part,
  output logic [37:0]        out_bin_frequency,
  output logic               out_last_bin
);

  dftr_pkg::q_entry_t push_entry;
  dftr_pkg::q_entry_t pop_entry;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  logic [31:0]        freq_step_r;
  logic [31:0]        freq_step_nxt;

  // config register: always ready, take the word on valid
  assign cfg_ready = 1'b1;

  always_comb begin
    freq_step_nxt = freq_step_r;
    if (cfg_valid && cfg_ready) begin
      freq_step_nxt = cfg_freq_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_step_r <= dftr_pkg::FREQ_STEP_RESET;
    end else begin
      freq_step_r <= freq_step_nxt;
    end
  end

  // hold off new samples only when the queue has no room
  assign busy = q_full;

  dftr_front #(.POINTS(POINTS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_sample),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  dftr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  dftr_back #(.POINTS(POINTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_entry           (pop_entry),
    .pop               (pop),
    .freq_step         (freq_step_r),
    .out_valid         (out_valid),
    .out_bin_index     (out_bin_index),
    .out_real_part     (out_real_part),
    .out_imag_part     (out_imag_part),
    .out_bin_frequency (out_bin_frequency),
    .out_last_bin      (out_last_bin)
  );

endmodule

// ===== rtl/dftr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dftr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dftr_front.sv =====
// Front end: accept samples, tag each with its slot and the end-of-block flag.
// Depends on dftr_pkg.
`timescale 1ns / 1ps

module dftr_front #(
  parameter int POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         sample,
  input  logic                q_full,
  output logic                push,
  output dftr_pkg::q_entry_t  entry
);

  localparam int IDX_W = $clog2(POINTS);
  localparam int IMW   = dftr_pkg::IDX_MAX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POINTS - 1);

  logic [IDX_W-1:0] load_count_r;
  logic [IDX_W-1:0] load_count_nxt;

  assign push = start && !q_full;

  always_comb begin
    load_count_nxt = load_count_r;
    if (push) begin
      load_count_nxt = (load_count_r == LAST) ? '0 : load_count_r + 1'b1;
    end
  end

  always_comb begin
    entry.idx    = IMW'(load_count_r);
    entry.last   = (load_count_r == LAST);
    entry.sample = signed'(sample);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

endmodule

// ===== rtl/dftr_queue.sv =====
// Short FIFO of tagged samples between the front end and the compute engine.
// Depends on dftr_pkg.
`timescale 1ns / 1ps

module dftr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dftr_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output dftr_pkg::q_entry_t  pop_entry,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = dftr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  dftr_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/dftr_back.sv =====
// Compute engine: store a block of samples, then run one shared
// multiply-accumulate over every (bin, sample) pair. Depends on dftr_pkg, dftr_ram.
`timescale 1ns / 1ps

module dftr_back #(
  parameter int POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  dftr_pkg::q_entry_t  q_entry,
  output logic                pop,
  input  logic [31:0]         freq_step,
  output logic                out_valid,
  output logic [5:0]          out_bin_index,
  output logic signed [22:0]  out_real_part,
  output logic signed [22:0]  out_imag_part,
  output logic [37:0]         out_bin_frequency,
  output logic                out_last_bin
);

  localparam int IDX_W = $clog2(POINTS);
  localparam int PH_W  = IDX_W + 1;
  localparam int SW    = dftr_pkg::SAMPLE_W;
  localparam int CW    = dftr_pkg::COEF_W;
  localparam int PW    = dftr_pkg::PROD_W;
  localparam int AW    = dftr_pkg::ACC_W;
  localparam int BW    = dftr_pkg::BIN_W;
  localparam int FW    = dftr_pkg::FREQ_W;
  localparam int RW    = dftr_pkg::PART_W;
  localparam int DROP  = dftr_pkg::FRAC_DROP;
  localparam longint unsigned PTS = POINTS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POINTS - 1);

  typedef struct packed {
    logic             v;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] k;
  } tag_t;

  // coefficient ROM, evaluated at elaboration
  logic signed [CW-1:0] cos_tab [POINTS];
  logic signed [CW-1:0] sin_tab [POINTS];

  for (genvar m = 0; m < POINTS; m++) begin : g_tab
    localparam longint unsigned R = (m <= POINTS - m) ? m : POINTS - m;
    localparam logic [63:0] THETA = (64'd2 * dftr_pkg::PI_Q28 * R + PTS / 2) / PTS;
    localparam logic signed [CW-1:0] COS_M = dftr_pkg::cos_q15(THETA);
    localparam logic signed [CW-1:0] SIN_M = dftr_pkg::sin_q15(THETA, m > POINTS - m);
    assign cos_tab[m] = COS_M;
    assign sin_tab[m] = SIN_M;
  end

  dftr_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] phase_r, phase_nxt;
  logic             issue;
  logic [PH_W-1:0]  ph_sum;

  tag_t                 s1_tag_r, s2_tag_r, s3_tag_r;
  logic [IDX_W-1:0]     s1_phase_r;
  logic [SW-1:0]        ram_rdata;
  logic signed [PW-1:0] prod_re, prod_im;
  logic signed [PW-1:0] s2_pre_r, s2_pim_r;
  logic signed [AW-1:0] acc_re_r, acc_re_nxt;
  logic signed [AW-1:0] acc_im_r, acc_im_nxt;
  logic [FW-1:0]        freq_prod;

  logic                 out_valid_r;
  logic [BW-1:0]        out_bin_r;
  logic signed [RW-1:0] out_re_r, out_im_r;
  logic [FW-1:0]        out_freq_r;
  logic                 out_last_r;

  dftr_ram #(.WIDTH(SW), .DEPTH(POINTS)) u_store (
    .clk   (clk),
    .we    (pop),
    .waddr (q_entry.idx[IDX_W-1:0]),
    .wdata (q_entry.sample),
    .raddr (n_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dftr_pkg::B_LOAD: begin
        if (!q_empty && q_entry.last) begin
          state_nxt = dftr_pkg::B_RUN;
        end
      end
      dftr_pkg::B_RUN: begin
        if (n_r == LAST && k_r == LAST) begin
          state_nxt = dftr_pkg::B_LOAD;
        end
      end
      default: state_nxt = dftr_pkg::B_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    case (state_r)
      dftr_pkg::B_LOAD: pop   = !q_empty;
      dftr_pkg::B_RUN:  issue = 1'b1;
      default: begin
        pop   = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  // bin / sample counters; phase tracks (k*n) mod POINTS
  assign ph_sum = {1'b0, phase_r} + {1'b0, k_r};

  always_comb begin
    k_nxt     = k_r;
    n_nxt     = n_r;
    phase_nxt = phase_r;
    if (pop && q_entry.last) begin
      k_nxt     = '0;
      n_nxt     = '0;
      phase_nxt = '0;
    end else if (issue) begin
      if (n_r == LAST) begin
        n_nxt     = '0;
        phase_nxt = '0;
        k_nxt     = k_r + 1'b1;
      end else begin
        n_nxt     = n_r + 1'b1;
        phase_nxt = (ph_sum >= PH_W'(POINTS)) ? IDX_W'(ph_sum - PH_W'(POINTS))
                                              : ph_sum[IDX_W-1:0];
      end
    end
  end

  assign prod_re = signed'(ram_rdata) * cos_tab[s1_phase_r];
  assign prod_im = signed'(ram_rdata) * sin_tab[s1_phase_r];

  always_comb begin
    acc_re_nxt = (s2_tag_r.first ? AW'(0) : acc_re_r) + AW'(s2_pre_r);
    acc_im_nxt = (s2_tag_r.first ? AW'(0) : acc_im_r) - AW'(s2_pim_r);
  end

  assign freq_prod = FW'(s3_tag_r.k) * FW'(freq_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dftr_pkg::B_LOAD;
      k_r         <= '0;
      n_r         <= '0;
      phase_r     <= '0;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      phase_r     <= phase_nxt;
      s1_tag_r    <= '{v: issue, first: (n_r == '0), last: (n_r == LAST), k: k_r};
      s2_tag_r    <= s1_tag_r;
      s3_tag_r    <= '{v: s2_tag_r.v && s2_tag_r.last, first: 1'b0, last: 1'b0,
                       k: s2_tag_r.k};
      out_valid_r <= s3_tag_r.v;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    s1_phase_r <= phase_r;
    s2_pre_r   <= prod_re;
    s2_pim_r   <= prod_im;
    if (s2_tag_r.v) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
    if (s3_tag_r.v) begin
      out_bin_r  <= BW'(s3_tag_r.k);
      out_re_r   <= acc_re_r[DROP +: RW];
      out_im_r   <= acc_im_r[DROP +: RW];
      out_freq_r <= freq_prod;
      out_last_r <= (s3_tag_r.k == LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_index     = out_bin_r;
  assign out_real_part     = out_re_r;
  assign out_imag_part     = out_im_r;
  assign out_bin_frequency = out_freq_r;
  assign out_last_bin      = out_last_r;

endmodule

// ===== rtl/dftr_checker.sv =====
// Port-level checks of the DFT result stream, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps

module dftr_checker #(
  parameter int POINTS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [5:0]  out_bin_index,
  input logic [37:0] out_bin_frequency,
  input logic        out_last_bin
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // the final bin is not followed at once by another word
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |=> !out_valid)
    else $error("result word right after final bin");

  // each bin of a block but the final one is followed by another bin
  a_bin_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_bin |-> ##POINTS out_valid)
    else $error("next bin not POINTS cycles later");

  // and in ascending order
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_bin |-> ##POINTS
      (out_bin_index == 6'($past(out_bin_index, POINTS) + 6'd1)))
    else $error("bin index out of order");

  // bin zero sits at frequency zero
  a_bin0_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bin_index == 6'd0) |-> (out_bin_frequency == 38'd0))
    else $error("bin zero frequency not zero");

endmodule

bind direct_dft_real_input dftr_checker #(.POINTS(POINTS)) u_dftr_checker (.*);

// ===== bench/tb_direct_dft_real_input.sv =====
// Self-checking bench for direct_dft_real_input: drives blocks of 16-bit samples, predicts
// every bin of each 64-point transform and checks the out_ words in order.
// Depends on dftr_pkg (field widths and constants) and the direct_dft_real_input RTL.
`timescale 1ns / 1ps

module tb_direct_dft_real_input;

  localparam int SAMPLE_W  = dftr_pkg::SAMPLE_W;
  localparam int BIN_W     = dftr_pkg::BIN_W;
  localparam int PART_W    = dftr_pkg::PART_W;
  localparam int FREQ_W    = dftr_pkg::FREQ_W;
  localparam int STEP_W    = dftr_pkg::STEP_W;
  localparam int FRAC_DROP = dftr_pkg::FRAC_DROP;

  localparam int POINTS = 64;
  // allow a few whole-block transform times without any handshake before giving up
  localparam int QUIET_LIMIT = 5 * POINTS * POINTS;
  localparam longint unsigned PI_Q28_TB = 64'd843314857;

  // full-scale rails, zero, +/-1, alternating and split bit patterns
  localparam logic [SAMPLE_W-1:0] DIRECTED [12] = '{
    16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555,
    16'haaaa, 16'h8001, 16'h7ffe, 16'h00ff, 16'hff00, 16'h4000
  };

  // shape of the samples in one random block
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_RAILS,
    SHAPE_TINY,
    SHAPE_FLAT,
    SHAPE_IMPULSE,
    SHAPE_NYQUIST
  } block_shape_t;

  // one predicted bin word
  typedef struct packed {
    logic [BIN_W-1:0]         idx;
    logic signed [PART_W-1:0] re;
    logic signed [PART_W-1:0] im;
    logic [FREQ_W-1:0]        freq;
    logic                     last;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic cfg_valid = 1'b0;
  logic [STEP_W-1:0] cfg_freq_step = '0;

  logic busy;
  logic cfg_ready;
  logic out_valid;
  logic [BIN_W-1:0] out_bin_index;
  logic signed [PART_W-1:0] out_real_part;
  logic signed [PART_W-1:0] out_imag_part;
  logic [FREQ_W-1:0] out_bin_frequency;
  logic out_last_bin;

  // Q1.15 twiddle tables, indexed by (k*n) mod POINTS
  int cos_rom [POINTS];
  int sin_rom [POINTS];

  // predictor copy of the block state and the step register
  logic signed [SAMPLE_W-1:0] block_buf [POINTS];
  int unsigned fill_cnt = 0;
  logic [STEP_W-1:0] step_reg = dftr_pkg::FREQ_STEP_RESET;

  logic [SAMPLE_W-1:0] sample_q [$];
  bin_word_t pending_bins [$];

  int unsigned words_pushed = 0;
  int unsigned words_in = 0;
  int unsigned bins_seen = 0;
  int unsigned blocks_done = 0;
  int unsigned steps_written = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;
  int unsigned idle_pct = 0;

  block_shape_t shape = SHAPE_UNIFORM;
  logic [SAMPLE_W-1:0] shape_val = '0;
  int unsigned shape_pos = 0;

  direct_dft_real_input #(
    .POINTS(POINTS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_freq_step    (cfg_freq_step),
    .out_valid        (out_valid),
    .out_bin_index    (out_bin_index),
    .out_real_part    (out_real_part),
    .out_imag_part    (out_imag_part),
    .out_bin_frequency(out_bin_frequency),
    .out_last_bin     (out_last_bin)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Twiddle tables: truncated Taylor series in Q28, rounded to Q1.15
  // ---------------------------------------------------------------------------

  // alternating series of cos (odd_terms = 0) or sin (odd_terms = 1)
  function automatic longint series_q28(input longint unsigned ang, input bit odd_terms);
    longint unsigned sq;
    longint unsigned t;
    longint unsigned dv;
    longint acc;
    sq  = (ang * ang) >> 28;
    t   = odd_terms ? ang : (64'd1 << 28);
    acc = longint'(t);
    for (int i = 1; i <= 12; i++) begin
      dv = odd_terms ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
      t  = ((t * sq) >> 28) / dv;
      if (i % 2 == 1) begin
        acc -= longint'(t);
      end else begin
        acc += longint'(t);
      end
    end
    return acc;
  endfunction

  // round the magnitude, then saturate to 16-bit signed
  function automatic int to_q15(input longint v);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    r   = (mag + 64'd4096) >> 13;
    if (v < 0) begin
      return (r >= 64'd32768) ? -32768 : -int'(r);
    end
    return (r > 64'd32767) ? 32767 : int'(r);
  endfunction

  function automatic void build_rom();
    int unsigned other;
    int unsigned r;
    longint unsigned ang;
    longint s;
    for (int m = 0; m < POINTS; m++) begin
      other = POINTS - m;
      r     = (m <= other) ? m : other;
      ang   = (64'd2 * PI_Q28_TB * r + POINTS / 2) / POINTS;
      s     = series_q28(ang, 1'b1);
      // second half of the circle: sine changes sign
      if (m > other) begin
        s = -s;
      end
      cos_rom[m] = to_q15(series_q28(ang, 1'b0));
      sin_rom[m] = to_q15(s);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: collect one block, then work out every bin of its transform
  // ---------------------------------------------------------------------------
  function automatic void load_sample(input logic [SAMPLE_W-1:0] w);
    longint acc_re;
    longint acc_im;
    longint fl_re;
    longint fl_im;
    logic [63:0] f;
    bin_word_t b;
    int unsigned idx;
    block_buf[fill_cnt] = signed'(w);
    fill_cnt++;
    if (fill_cnt != POINTS) begin
      return;
    end
    fill_cnt = 0;
    blocks_done++;
    for (int k = 0; k < POINTS; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int n = 0; n < POINTS; n++) begin
        idx     = (k * n) % POINTS;
        acc_re += longint'(block_buf[n]) * cos_rom[idx];
        acc_im -= longint'(block_buf[n]) * sin_rom[idx];
      end
      // arithmetic shift floors negative sums toward minus infinity
      fl_re  = acc_re >>> FRAC_DROP;
      fl_im  = acc_im >>> FRAC_DROP;
      f      = 64'(k) * 64'(step_reg);
      b.idx  = BIN_W'(k);
      b.re   = fl_re[PART_W-1:0];
      b.im   = fl_im[PART_W-1:0];
      b.freq = f[FREQ_W-1:0];
      b.last = (k == POINTS - 1);
      pending_bins.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sample source: directed words first, then blocks of a random shape
  // ---------------------------------------------------------------------------
  function automatic logic [SAMPLE_W-1:0] next_word();
    int unsigned pos;
    pos = words_pushed % POINTS;
    if (words_pushed < $size(DIRECTED)) begin
      return DIRECTED[words_pushed];
    end
    // pick a fresh shape at each block boundary
    if (pos == 0) begin
      shape     = block_shape_t'($urandom_range(SHAPE_NYQUIST, SHAPE_UNIFORM));
      shape_val = SAMPLE_W'($urandom);
      shape_pos = $urandom_range(POINTS - 1);
    end
    case (shape)
      SHAPE_RAILS:   return $urandom_range(1) ? 16'h7fff : 16'h8000;
      SHAPE_TINY:    return SAMPLE_W'($urandom_range(15)) - 16'd8;
      SHAPE_FLAT:    return shape_val;
      SHAPE_IMPULSE: return (pos == shape_pos) ? shape_val : 16'h0000;
      SHAPE_NYQUIST: return pos[0] ? -shape_val : shape_val;
      default:       return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending word, hold it until busy drops
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // word taken at this edge: feed the predictor before counting it
      if (start && !busy) begin
        load_sample(in_sample);
        words_in++;
      end
      if (!start || !busy) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_sample <= sample_q.pop_front();
          start     <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed bin word must match the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bin_word_t want;
    if (rst_n && out_valid) begin
      bins_seen++;
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected bin word: k=%0d re=%0d im=%0d f=%0d last=%0b",
                   out_bin_index, out_real_part, out_imag_part, out_bin_frequency,
                   out_last_bin);
        end
      end else begin
        want = pending_bins.pop_front();
        if (want.idx !== out_bin_index || want.re !== out_real_part ||
            want.im !== out_imag_part || want.freq !== out_bin_frequency ||
            want.last !== out_last_bin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("bin mismatch: exp k=%0d re=%0d im=%0d f=%0d last=%0b",
                     want.idx, want.re, want.im, want.freq, want.last);
            $display("              got k=%0d re=%0d im=%0d f=%0d last=%0b",
                     out_bin_index, out_real_part, out_imag_part, out_bin_frequency,
                     out_last_bin);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no handshake on any port
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("tb_direct_dft_real_input NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // hold until every queued word is taken and every predicted bin has arrived
  task automatic wait_drained();
    while (words_in != words_pushed || pending_bins.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // queue count words; with per_block set, pause after each block until it drains
  task automatic run_phase(input int unsigned pct, input int unsigned count,
                           input bit per_block);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      sample_q.push_back(next_word());
      words_pushed++;
      if (per_block && words_pushed % POINTS == 0) begin
        wait_drained();
      end
    end
    wait_drained();
    // let leftover words of a partial block settle in the store
    repeat (2 * POINTS) @(posedge clk);
  endtask

  // write the step register; called right after a rising edge
  task automatic write_step(input logic [STEP_W-1:0] v);
    cfg_freq_step <= v;
    cfg_valid     <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    step_reg = v;
    steps_written++;
  endtask

  initial begin
    build_rom();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // back to back, step at its reset value; directed words open the first block
    run_phase(0, 2 * POINTS, 1'b0);
    // largest step, sender mostly idle
    write_step(32'hffff_ffff);
    run_phase(82, 96, 1'b0);
    // zero step, back to back again (block boundaries now fall mid phase)
    write_step(32'h0000_0000);
    run_phase(0, 96, 1'b0);
    // random step, sender idle about a third of the time, drain after each block
    write_step(STEP_W'($urandom));
    run_phase(37, POINTS, 1'b1);
    write_step(STEP_W'($urandom));
    run_phase(0, POINTS, 1'b1);

    $display("%0d samples taken, %0d transforms predicted, %0d bin words checked",
             words_in, blocks_done, bins_seen);
    $display("%0d step settings written, %0d mismatches", steps_written, mismatches);
    if (mismatches == 0) begin
      $display("tb_direct_dft_real_input OK");
    end else begin
      $display("tb_direct_dft_real_input NOT OK");
    end
    $finish;
  end

endmodule
